### rtl/core/assert_macros.svh
// Assertion macros for the voxel map core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VRM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define VRM_NEVER(label, clk, rst_n, expr) \
    `VRM_ASSERT(label, clk, rst_n, !(expr))
`else
`define VRM_ASSERT(label, clk, rst_n, prop)
`define VRM_NEVER(label, clk, rst_n, expr)
`endif
`endif

### rtl/core/vrm_pkg.sv
// Shared types and constants for the voxel reservoir map
package vrm_pkg;

    localparam int TABLE_DEPTH_DEF     = 1024;
    localparam int SLOTS_PER_VOXEL_DEF = 32;

    localparam logic [1:0] CFG_VOX_EDGE   = 2'd0;
    localparam logic [1:0] CFG_SLOT_LIMIT = 2'd1;
    localparam logic [1:0] CFG_KEEP_RANGE = 2'd2;

    localparam logic [2:0] ST_APPEND  = 3'd0;
    localparam logic [2:0] ST_REPLACE = 3'd1;
    localparam logic [2:0] ST_DISCARD = 3'd2;
    localparam logic [2:0] ST_SKIP    = 3'd3;
    localparam logic [2:0] ST_CLASH   = 3'd4;
    localparam logic [2:0] ST_PRUNED  = 3'd5;

    typedef enum logic [1:0] {
        K_INSERT,
        K_SKIP,
        K_PRUNE
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] rnd;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  vslot;
        logic [4:0]  pslot;
        logic [31:0] seen;
        logic [10:0] pruned;
    } result_t;

    typedef struct packed {
        logic [15:0] vox_edge;
        logic [5:0]  slot_limit;
        logic [19:0] keep_range;
    } cfg_t;

endpackage

### rtl/core/voxel_reservoir_map_top.sv
// Top level of the voxel reservoir map: config registers, request and result queues
// Insert: the result for an append or a table clash follows the key division, hash and table
// read; when the voxel is full the reservoir modulo runs too (key and slot dividers).
// Skipped point: no table work. Prune: reads each entry; valid ones add gap, square and compare.
// One request at a time in the engine, the next taken after its result; queues hold two.
// Reset: a clearing pass over the table zeroes every entry; full stays high until it ends.
`include "assert_macros.svh"
module voxel_reservoir_map_top
    import vrm_pkg::*;
#(
    parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
    parameter int SLOTS_PER_VOXEL = SLOTS_PER_VOXEL_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic               mode,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic               point_finite,
    input  logic [31:0]        random_word,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         status,
    output logic [9:0]         voxel_slot,
    output logic [4:0]         point_slot,
    output logic [31:0]        seen_count,
    output logic [10:0]        pruned_count
);

    cfg_t    cfg_reg;
    item_t   fr_head;
    logic    fr_empty, fr_pop, bk_clearing, oq_full, bk_push;
    result_t bk_res, oq_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vox_edge   <= 16'd512;
            cfg_reg.slot_limit <= 6'd20;
            cfg_reg.keep_range <= 20'd102400;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_VOX_EDGE:   cfg_reg.vox_edge   <= cfg_data[15:0];
                CFG_SLOT_LIMIT: cfg_reg.slot_limit <= cfg_data[5:0];
                CFG_KEEP_RANGE: cfg_reg.keep_range <= cfg_data;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    vrm_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .hold(bk_clearing),
        .mode(mode), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .point_finite(point_finite), .random_word(random_word),
        .pop(fr_pop), .empty(fr_empty), .head(fr_head)
    );

    vrm_back #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .SLOTS_PER_VOXEL(SLOTS_PER_VOXEL)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .fr_empty(fr_empty), .fr_head(fr_head),
        .fr_pop(fr_pop), .clearing(bk_clearing), .oq_full(oq_full), .bk_push(bk_push),
        .bk_res(bk_res)
    );

    vrm_outq u_outq (
        .clk(clk), .rst_n(rst_n), .push(bk_push), .din(bk_res), .full(oq_full),
        .pop(pop), .empty(empty), .dout(oq_head)
    );

    assign status       = oq_head.status;
    assign voxel_slot   = oq_head.vslot;
    assign point_slot   = oq_head.pslot;
    assign seen_count   = oq_head.seen;
    assign pruned_count = oq_head.pruned;

    `VRM_ASSERT(a_clear_holds_input, clk, rst_n, bk_clearing |-> full)
    `VRM_NEVER(a_push_into_full, clk, rst_n, bk_push && oq_full)
    `VRM_ASSERT(a_status_code, clk, rst_n, !empty |-> (status <= ST_PRUNED))
    `VRM_ASSERT(a_clear_no_result, clk, rst_n, bk_clearing |-> !bk_push)

endmodule

### rtl/core/vrm_front.sv
// Input queue that classifies each request before the engine takes it
module vrm_front
    import vrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        hold,
    input  logic        mode,
    input  logic [31:0] coord_x,
    input  logic [31:0] coord_y,
    input  logic [31:0] coord_z,
    input  logic        point_finite,
    input  logic [31:0] random_word,
    input  logic        pop,
    output logic        empty,
    output item_t       head
);

    item_t      q_mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;
    item_t      in_item;

    assign full    = (cnt_reg == 2'd2) || hold;
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = q_mem[rp_reg];

    always_comb
    begin
        in_item.kind = mode ? K_PRUNE : (point_finite ? K_INSERT : K_SKIP);
        in_item.cx   = coord_x;
        in_item.cy   = coord_y;
        in_item.cz   = coord_z;
        in_item.rnd  = random_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wp_reg <= ~wp_reg;
            if (do_pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wp_reg] <= in_item;
    end

endmodule

### rtl/core/vrm_div.sv
// Restoring unsigned divider, one quotient bit per cycle
module vrm_div
    import vrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quot,
    output logic [31:0] rem
);

    logic        run_reg, done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] r_reg, q_reg, d_reg;
    logic [32:0] r_shift, r_sub;
    logic        fits;

    assign r_shift = {r_reg, q_reg[31]};
    assign r_sub   = r_shift - {1'b0, d_reg};
    assign fits    = r_shift >= {1'b0, d_reg};
    assign done    = done_reg;
    assign quot    = q_reg;
    assign rem     = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= 32'd0;
            q_reg <= dividend;
            d_reg <= divisor;
        end
        else if (run_reg)
        begin
            r_reg <= fits ? r_sub[31:0] : r_shift[31:0];
            q_reg <= {q_reg[30:0], fits};
        end
    end

endmodule

### rtl/core/vrm_back.sv
// Voxel table engine: key division, hashing, reservoir update and prune walk
module vrm_back
    import vrm_pkg::*;
#(
    parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
    parameter int SLOTS_PER_VOXEL = SLOTS_PER_VOXEL_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    fr_empty,
    input  item_t   fr_head,
    output logic    fr_pop,
    output logic    clearing,
    input  logic    oq_full,
    output logic    bk_push,
    output result_t bk_res
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int SLOT_W = (SLOTS_PER_VOXEL > 1) ? $clog2(SLOTS_PER_VOXEL) : 1;
    localparam int FILL_W = $clog2(SLOTS_PER_VOXEL + 1);
    localparam int PS_D   = TABLE_DEPTH * SLOTS_PER_VOXEL;
    localparam int PS_W   = $clog2(PS_D);

    typedef struct packed {
        logic              valid;
        logic [31:0]       kx;
        logic [31:0]       ky;
        logic [31:0]       kz;
        logic [31:0]       seen;
        logic [FILL_W-1:0] fill;
    } ent_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_HASH, S_XOR, S_RD, S_EVAL, S_RMOD,
        S_EMIT, S_PRD, S_PGAP, S_PABS, S_PSQ, S_PCMP
    } state_t;

    ent_t        ent_mem [TABLE_DEPTH];
    logic [95:0] ps_mem  [PS_D];

    state_t      state_reg;
    logic [IDX_W-1:0] walk_reg, idx_reg;
    item_t       item_reg;
    logic [15:0] vs_reg;
    logic [31:0] key_reg [3];
    logic [31:0] prod_reg [3];
    logic [31:0] seen_reg;
    logic [FILL_W-1:0] fill_reg;
    result_t     res_reg;
    logic [10:0] pruned_reg;
    logic [20:0] t_reg;
    logic [41:0] tt_reg;
    logic signed [50:0] pm_reg [3];
    logic [51:0] gap_reg [3];
    logic [41:0] sq_reg [3];
    logic        big_reg;
    ent_t        ent_rd_reg, ent_cur_reg;

    logic        ent_we;
    logic [IDX_W-1:0] ent_wa, rd_addr;
    ent_t        ent_wd;
    logic        ps_we;
    logic [SLOT_W-1:0] ps_slot;
    logic [PS_W-1:0]   ps_addr;

    logic        d0_start, d12_start, d0_done;
    logic [31:0] d0_a, d0_b, vs_div;
    logic [31:0] dq [3];
    logic [31:0] dr [3];
    logic [31:0] crd [3];
    logic [31:0] mag [3];
    logic [31:0] key_c [3];
    logic [31:0] key_rd [3];
    logic [31:0] org [3];
    logic [31:0] h_c, j_w, fill_w, idx_w;
    logic [15:0] vs_eff;
    logic [6:0]  lim7;
    logic        take, clash, far;
    logic [31:0] base_seen, new_seen;
    logic [FILL_W-1:0] base_fill;
    logic [20:0] t_c;
    logic [41:0] tt_c;
    logic [43:0] sum_c;

    assign clearing = (state_reg == S_CLEAR);
    assign take     = (state_reg == S_IDLE) && !fr_empty;
    assign fr_pop   = take;
    assign bk_push  = (state_reg == S_EMIT) && !oq_full;
    assign bk_res   = res_reg;
    assign rd_addr  = (state_reg == S_PRD) ? walk_reg : idx_reg;

    assign vs_eff = (cfg.vox_edge == 16'd0) ? 16'd1 : cfg.vox_edge;
    assign vs_div = {16'd0, vs_eff};
    assign lim7   = (cfg.slot_limit == 6'd0) ? 7'd1 :
                    ((7'(cfg.slot_limit) > 7'(SLOTS_PER_VOXEL)) ? 7'(SLOTS_PER_VOXEL)
                                                              : 7'(cfg.slot_limit));
    assign t_c    = {cfg.keep_range, 1'b0};
    assign tt_c   = t_c * t_c;

    assign crd[0] = fr_head.cx;
    assign crd[1] = fr_head.cy;
    assign crd[2] = fr_head.cz;
    assign org[0] = item_reg.cx;
    assign org[1] = item_reg.cy;
    assign org[2] = item_reg.cz;
    assign key_rd[0] = ent_rd_reg.kx;
    assign key_rd[1] = ent_rd_reg.ky;
    assign key_rd[2] = ent_rd_reg.kz;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mag[a] = crd[a][31] ? (32'd0 - crd[a]) : crd[a];
            if (!org[a][31])
                key_c[a] = dq[a];
            else
                key_c[a] = (dr[a] != 32'd0) ? ~dq[a] : (32'd0 - dq[a]);
        end
    end

    assign h_c = prod_reg[0] ^ prod_reg[1] ^ prod_reg[2];

    assign clash = ent_rd_reg.valid &&
                   ((ent_rd_reg.kx != key_reg[0]) || (ent_rd_reg.ky != key_reg[1]) ||
                    (ent_rd_reg.kz != key_reg[2]));
    assign base_seen = ent_rd_reg.valid ? ent_rd_reg.seen : 32'd0;
    assign base_fill = ent_rd_reg.valid ? ent_rd_reg.fill : '0;
    assign new_seen  = (base_seen == 32'hFFFF_FFFF) ? base_seen : base_seen + 32'd1;
    assign j_w       = dr[0];
    assign fill_w    = 32'(base_fill);
    assign idx_w     = 32'(idx_reg);

    assign sum_c = 44'(sq_reg[0]) + 44'(sq_reg[1]) + 44'(sq_reg[2]);
    assign far   = big_reg || (sum_c > 44'(tt_reg));

    assign d12_start = take && (fr_head.kind == K_INSERT);
    always_comb
    begin
        d0_start = 1'b0;
        d0_a     = mag[0];
        d0_b     = vs_div;
        if (d12_start)
            d0_start = 1'b1;
        else if ((state_reg == S_EVAL) && !clash && !(7'(base_fill) < lim7))
        begin
            d0_start = 1'b1;
            d0_a     = item_reg.rnd;
            d0_b     = new_seen;
        end
    end

    vrm_div u_div0 (
        .clk(clk), .rst_n(rst_n), .start(d0_start), .dividend(d0_a), .divisor(d0_b),
        .done(d0_done), .quot(dq[0]), .rem(dr[0])
    );

    vrm_div u_div1 (
        .clk(clk), .rst_n(rst_n), .start(d12_start), .dividend(mag[1]), .divisor(vs_div),
        .done(), .quot(dq[1]), .rem(dr[1])
    );

    vrm_div u_div2 (
        .clk(clk), .rst_n(rst_n), .start(d12_start), .dividend(mag[2]), .divisor(vs_div),
        .done(), .quot(dq[2]), .rem(dr[2])
    );

    always_comb
    begin
        ent_we  = 1'b0;
        ent_wa  = idx_reg;
        ent_wd  = '0;
        ps_we   = 1'b0;
        ps_slot = SLOT_W'(base_fill);
        case (state_reg)
            S_CLEAR:
            begin
                ent_we = 1'b1;
                ent_wa = walk_reg;
            end
            S_EVAL:
            begin
                if (!clash && (7'(base_fill) < lim7))
                begin
                    ent_we = 1'b1;
                    ent_wd = '{1'b1, key_reg[0], key_reg[1], key_reg[2], new_seen,
                               base_fill + FILL_W'(1)};
                    ps_we  = 1'b1;
                end
            end
            S_RMOD:
            begin
                if (d0_done)
                begin
                    ent_we  = 1'b1;
                    ent_wd  = '{1'b1, key_reg[0], key_reg[1], key_reg[2], seen_reg, fill_reg};
                    ps_we   = j_w < 32'(lim7);
                    ps_slot = SLOT_W'(j_w);
                end
            end
            S_PCMP:
            begin
                ent_we       = far;
                ent_wa       = walk_reg;
                ent_wd       = ent_cur_reg;
                ent_wd.valid = 1'b0;
            end
            default:
            begin
                ent_we = 1'b0;
            end
        endcase
    end

    assign ps_addr = PS_W'(idx_w * 32'(SLOTS_PER_VOXEL) + 32'(ps_slot));

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_wa] <= ent_wd;
        ent_rd_reg <= ent_mem[rd_addr];
        if (ps_we)
            ps_mem[ps_addr] <= {item_reg.cx, item_reg.cy, item_reg.cz};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            walk_reg   <= '0;
            pruned_reg <= 11'd0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    if (walk_reg == IDX_W'(TABLE_DEPTH - 1))
                    begin
                        walk_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                        walk_reg <= walk_reg + IDX_W'(1);
                end
                S_IDLE:
                begin
                    if (take)
                    begin
                        item_reg <= fr_head;
                        vs_reg   <= vs_eff;
                        case (fr_head.kind)
                            K_INSERT: state_reg <= S_DIV;
                            K_PRUNE:
                            begin
                                walk_reg   <= '0;
                                pruned_reg <= 11'd0;
                                t_reg      <= t_c;
                                tt_reg     <= tt_c;
                                state_reg  <= S_PRD;
                            end
                            default:
                            begin
                                res_reg   <= '{ST_SKIP, 10'd0, 5'd0, 32'd0, 11'd0};
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (d0_done)
                    begin
                        for (int a = 0; a < 3; a++)
                            key_reg[a] <= key_c[a];
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    prod_reg[0] <= key_reg[0] * 32'd73856093;
                    prod_reg[1] <= key_reg[1] * 32'd19349663;
                    prod_reg[2] <= key_reg[2] * 32'd83492791;
                    state_reg   <= S_XOR;
                end
                S_XOR:
                begin
                    idx_reg   <= h_c[IDX_W-1:0];
                    state_reg <= S_RD;
                end
                S_RD:
                    state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (clash)
                    begin
                        res_reg   <= '{ST_CLASH, idx_w[9:0], 5'd0, 32'd0, 11'd0};
                        state_reg <= S_EMIT;
                    end
                    else if (7'(base_fill) < lim7)
                    begin
                        res_reg   <= '{ST_APPEND, idx_w[9:0], fill_w[4:0], new_seen, 11'd0};
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        seen_reg  <= new_seen;
                        fill_reg  <= base_fill;
                        state_reg <= S_RMOD;
                    end
                end
                S_RMOD:
                begin
                    if (d0_done)
                    begin
                        if (j_w < 32'(lim7))
                            res_reg <= '{ST_REPLACE, idx_w[9:0], j_w[4:0], seen_reg, 11'd0};
                        else
                            res_reg <= '{ST_DISCARD, idx_w[9:0], 5'd0, seen_reg, 11'd0};
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!oq_full)
                        state_reg <= S_IDLE;
                end
                S_PRD:
                    state_reg <= S_PGAP;
                S_PGAP:
                begin
                    ent_cur_reg <= ent_rd_reg;
                    for (int a = 0; a < 3; a++)
                        pm_reg[a] <= $signed({key_rd[a][31], key_rd[a], 1'b1}) *
                                     $signed({1'b0, vs_reg});
                    if (ent_rd_reg.valid)
                        state_reg <= S_PABS;
                    else if (walk_reg == IDX_W'(TABLE_DEPTH - 1))
                    begin
                        res_reg   <= '{ST_PRUNED, 10'd0, 5'd0, 32'd0, pruned_reg};
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        walk_reg  <= walk_reg + IDX_W'(1);
                        state_reg <= S_PRD;
                    end
                end
                S_PABS:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        logic signed [51:0] d;
                        d = $signed({pm_reg[a][50], pm_reg[a]}) -
                            $signed({{19{org[a][31]}}, org[a], 1'b0});
                        gap_reg[a] <= d[51] ? 52'(-d) : 52'(d);
                    end
                    state_reg <= S_PSQ;
                end
                S_PSQ:
                begin
                    big_reg <= (gap_reg[0] > 52'(t_reg)) || (gap_reg[1] > 52'(t_reg)) ||
                               (gap_reg[2] > 52'(t_reg));
                    for (int a = 0; a < 3; a++)
                        sq_reg[a] <= gap_reg[a][20:0] * gap_reg[a][20:0];
                    state_reg <= S_PCMP;
                end
                S_PCMP:
                begin
                    logic [10:0] cnt;
                    cnt = pruned_reg;
                    if (far && (pruned_reg != 11'h7FF))
                        cnt = pruned_reg + 11'd1;
                    pruned_reg <= cnt;
                    if (walk_reg == IDX_W'(TABLE_DEPTH - 1))
                    begin
                        res_reg   <= '{ST_PRUNED, 10'd0, 5'd0, 32'd0, cnt};
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        walk_reg  <= walk_reg + IDX_W'(1);
                        state_reg <= S_PRD;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/vrm_outq.sv
// Two-entry result queue towards the consumer
module vrm_outq
    import vrm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t din,
    output logic    full,
    input  logic    pop,
    output logic    empty,
    output result_t dout
);

    result_t    q_mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = q_mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wp_reg <= ~wp_reg;
            if (do_pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wp_reg] <= din;
    end

endmodule

### tb/tb_voxel_reservoir_map_top.sv
// Testbench for the voxel reservoir map: queued requests, predicted results, random handshakes
`timescale 1ns / 100ps
module tb_voxel_reservoir_map_top;
    import vrm_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD = 600;

    typedef struct {
        bit        mode;
        bit [31:0] x;
        bit [31:0] y;
        bit [31:0] z;
        bit        fin;
        bit [31:0] rnd;
    } point_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [19:0] cfg_data = '0;
    logic push = 1'b0;
    logic full;
    logic mode = 1'b0;
    logic signed [31:0] coord_x = '0;
    logic signed [31:0] coord_y = '0;
    logic signed [31:0] coord_z = '0;
    logic point_finite = 1'b0;
    logic [31:0] random_word = '0;
    logic empty;
    logic pop = 1'b0;
    logic [2:0] status;
    logic [9:0] voxel_slot;
    logic [4:0] point_slot;
    logic [31:0] seen_count;
    logic [10:0] pruned_count;

    voxel_reservoir_map_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .mode(mode), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .point_finite(point_finite), .random_word(random_word),
        .empty(empty), .pop(pop),
        .status(status), .voxel_slot(voxel_slot), .point_slot(point_slot),
        .seen_count(seen_count), .pruned_count(pruned_count)
    );

    always #10 clk = ~clk;

    // predictor copy of the map
    bit [15:0] m_vox_edge = 16'd512;
    bit [5:0]  m_slot_limit = 6'd20;
    bit [19:0] m_keep_range = 20'd102400;
    bit        m_valid [1024];
    bit [31:0] m_kx [1024];
    bit [31:0] m_ky [1024];
    bit [31:0] m_kz [1024];
    bit [31:0] m_seen [1024];
    bit [5:0]  m_fill [1024];

    point_req_t pending_reqs[$];
    result_t    awaited_results[$];
    point_req_t cur_req;
    int  fails = 0;
    int  status_hits [8];
    bit  quiet = 1'b0;
    bit  sender_pause = 1'b0;
    bit  long_hold_req = 1'b0;
    longint cycles = 0;

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        fails++;
    endtask

    function automatic bit [31:0] floor_key(longint c, longint vs);
        longint q;
        q = c / vs;
        if ((c % vs) != 0 && c < 0)
            q--;
        return q[31:0];
    endfunction

    function automatic longint centre_gap(bit [31:0] key, longint vs, longint origin);
        longint d;
        d = (2 * longint'($signed(key)) + 1) * vs - 2 * origin;
        return d < 0 ? -d : d;
    endfunction

    function automatic result_t apply_request(point_req_t r);
        result_t res;
        longint cx, cy, cz, vs, t, dx, dy, dz;
        bit [31:0] kx, ky, kz, h, lim, j;
        int idx;
        bit far;
        res = '0;
        cx = longint'($signed(r.x));
        cy = longint'($signed(r.y));
        cz = longint'($signed(r.z));
        vs = (m_vox_edge == 0) ? 1 : longint'(m_vox_edge);
        if (r.mode) begin
            t = 2 * longint'(m_keep_range);
            for (int i = 0; i < 1024; i++) begin
                if (m_valid[i]) begin
                    dx = centre_gap(m_kx[i], vs, cx);
                    dy = centre_gap(m_ky[i], vs, cy);
                    dz = centre_gap(m_kz[i], vs, cz);
                    if (dx > t || dy > t || dz > t)
                        far = 1'b1;
                    else
                        far = dx * dx + dy * dy + dz * dz > t * t;
                    if (far) begin
                        m_valid[i] = 1'b0;
                        if (res.pruned != 11'd2047)
                            res.pruned++;
                    end
                end
            end
            res.status = ST_PRUNED;
        end else if (!r.fin) begin
            res.status = ST_SKIP;
        end else begin
            kx = floor_key(cx, vs);
            ky = floor_key(cy, vs);
            kz = floor_key(cz, vs);
            h = (kx * 32'd73856093) ^ (ky * 32'd19349663) ^ (kz * 32'd83492791);
            idx = h[9:0];
            lim = (m_slot_limit == 0) ? 1 : (m_slot_limit > 32 ? 32 : m_slot_limit);
            res.vslot = h[9:0];
            if (m_valid[idx] && (m_kx[idx] != kx || m_ky[idx] != ky || m_kz[idx] != kz)) begin
                res.status = ST_CLASH;
            end else begin
                if (!m_valid[idx]) begin
                    m_valid[idx] = 1'b1;
                    m_kx[idx] = kx;
                    m_ky[idx] = ky;
                    m_kz[idx] = kz;
                    m_seen[idx] = 0;
                    m_fill[idx] = 0;
                end
                if (m_seen[idx] != 32'hFFFF_FFFF)
                    m_seen[idx]++;
                res.seen = m_seen[idx];
                if (m_fill[idx] < lim) begin
                    res.pslot = m_fill[idx][4:0];
                    m_fill[idx]++;
                    res.status = ST_APPEND;
                end else begin
                    j = r.rnd % m_seen[idx];
                    if (j < lim) begin
                        res.pslot = j[4:0];
                        res.status = ST_REPLACE;
                    end else begin
                        res.status = ST_DISCARD;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic bit [31:0] near_coord(int span);
        longint vs;
        longint v;
        vs = (m_vox_edge == 0) ? 1 : longint'(m_vox_edge);
        v = (longint'($urandom_range(0, 2 * span)) - span) * vs + $urandom_range(0, vs - 1);
        return v[31:0];
    endfunction

    function automatic point_req_t make_point(int span);
        point_req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.mode = ($urandom_range(0, 99) < 3);
        r.fin = ($urandom_range(0, 99) < 92);
        r.rnd = ($urandom_range(0, 19) == 0) ? 32'hFFFF_FFFF : $urandom;
        if (pick < 72) begin
            r.x = near_coord(span);
            r.y = near_coord(span);
            r.z = near_coord(span);
        end else if (pick < 90) begin
            r.x = $urandom;
            r.y = $urandom;
            r.z = $urandom;
        end else begin
            r.x = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            r.y = $urandom_range(0, 1) ? 32'h8000_0000 : 32'hFFFF_FFFF;
            r.z = $urandom_range(0, 1) ? 32'h0000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic point_req_t fixed_point(bit m, bit [31:0] x, bit [31:0] y,
                                               bit [31:0] z, bit f, bit [31:0] rnd);
        point_req_t r;
        r.mode = m;
        r.x = x;
        r.y = y;
        r.z = z;
        r.fin = f;
        r.rnd = rnd;
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_VOX_EDGE)
            m_vox_edge = val[15:0];
        else if (idx == CFG_SLOT_LIMIT)
            m_slot_limit = val[5:0];
        else if (idx == CFG_KEEP_RANGE)
            m_keep_range = val;
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_reqs.size() != 0 || push || awaited_results.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : sender
        int gap_left;
        if (!rst_n) begin
            push <= 1'b0;
            gap_left = 0;
        end else if (!(push && full)) begin
            if (push)
                awaited_results.insert(awaited_results.size(), apply_request(cur_req));
            if (gap_left != 0) begin
                push <= 1'b0;
                gap_left--;
            end else if (pending_reqs.size() != 0 && !sender_pause) begin
                cur_req = pending_reqs.pop_front();
                mode <= cur_req.mode;
                coord_x <= cur_req.x;
                coord_y <= cur_req.y;
                coord_z <= cur_req.z;
                point_finite <= cur_req.fin;
                random_word <= cur_req.rnd;
                push <= 1'b1;
                gap_left = quiet ? 0 : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 13) : 0);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin : receiver
        int stall_left;
        bit hold_taken;
        result_t want;
        if (!rst_n) begin
            pop <= 1'b0;
            stall_left = 0;
            hold_taken = 1'b0;
        end else begin
            if (pop && !empty) begin
                if (awaited_results.size() == 0) begin
                    report("unexpected result status", status, 0);
                end else begin
                    want = awaited_results.pop_front();
                    status_hits[status]++;
                    if (status !== want.status)
                        report("status", status, want.status);
                    if (voxel_slot !== want.vslot)
                        report("voxel_slot", voxel_slot, want.vslot);
                    if (point_slot !== want.pslot)
                        report("point_slot", point_slot, want.pslot);
                    if (seen_count !== want.seen)
                        report("seen_count", seen_count, want.seen);
                    if (pruned_count !== want.pruned)
                        report("pruned_count", pruned_count, want.pruned);
                end
                stall_left = quiet ? 0 : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 13) : 0);
            end
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left != 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        bit [15:0] vs_set [5] = '{16'd65535, 16'd1, 16'd0, 16'd2048, 16'd700};
        bit [5:0]  sl_set [5] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd2};
        bit [19:0] kr_set [5] = '{20'd1048575, 20'd1, 20'd300, 20'd20000, 20'd5000};
        int spans [5] = '{3, 4, 3, 2, 3};
        int total;
        for (int i = 0; i < 1024; i++)
            m_valid[i] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // one voxel filled past the slot limit, then extremes, a skip and a prune
        for (int i = 0; i < 21; i++)
            pending_reqs.insert(pending_reqs.size(),
                                fixed_point(1'b0, 32'd100, 32'd200, 32'd300, 1'b1,
                                            (i == 20) ? 32'd3 : $urandom));
        pending_reqs.insert(pending_reqs.size(),
                            fixed_point(1'b0, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 1'b1, 32'h0));
        pending_reqs.insert(pending_reqs.size(),
                            fixed_point(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF));
        pending_reqs.insert(pending_reqs.size(),
                            fixed_point(1'b0, 32'hFFFF_FFFF, 32'h0, 32'h1, 1'b0, 32'h0));
        pending_reqs.insert(pending_reqs.size(),
                            fixed_point(1'b1, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0));
        drain();

        total = 25;
        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_VOX_EDGE, vs_set[p]);
            write_reg(CFG_SLOT_LIMIT, sl_set[p]);
            write_reg(CFG_KEEP_RANGE, kr_set[p]);
            if (p == 1)
                write_reg(CFG_UNUSED, 20'hFFFFF);
            quiet = (p == 3);
            if (p == 2)
                long_hold_req = 1'b1;
            for (int n = 0; n < 265; n++) begin
                pending_reqs.insert(pending_reqs.size(), make_point(spans[p]));
                if (n == 130) begin
                    // hold new requests until the block has answered everything
                    while (pending_reqs.size() != 0)
                        @(negedge clk);
                    sender_pause = 1'b1;
                    while (push || awaited_results.size() != 0)
                        @(negedge clk);
                    sender_pause = 1'b0;
                end
                if (pending_reqs.size() > 8)
                    @(posedge clk);
            end
            total += 265;
            drain();
        end

        repeat (200) @(posedge clk);
        $display("covered %0d requests over 6 register settings in %0d cycles", total, cycles);
        $display("appended %0d replaced %0d discarded %0d skipped %0d clashed %0d pruned %0d",
                 status_hits[ST_APPEND], status_hits[ST_REPLACE], status_hits[ST_DISCARD],
                 status_hits[ST_SKIP], status_hits[ST_CLASH], status_hits[ST_PRUNED]);
        if (fails == 0 && awaited_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
